// ----- rtl/svpi_pkg.sv -----
// Shared types, codes and arithmetic helpers for the superheat valve PI controller.
`timescale 1ns / 1ps
`default_nettype none

package svpi_pkg;

   // item kinds on req_tuser
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_REQ   = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   // external status encoding
   localparam logic [1:0] STATUS_STARTING = 2'd0;
   localparam logic [1:0] STATUS_CLOSE    = 2'd1;
   localparam logic [1:0] STATUS_FIXED    = 2'd2;
   localparam logic [1:0] STATUS_MOD      = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_CONTROL_MODE    = 3'd0;
   localparam logic [2:0] CSR_MANUAL_POSITION = 3'd1;
   localparam logic [2:0] CSR_SETPOINT        = 3'd2;
   localparam logic [2:0] CSR_GAIN_P          = 3'd3;
   localparam logic [2:0] CSR_GAIN_I          = 3'd4;
   localparam logic [2:0] CSR_INT_LIMIT       = 3'd5;
   localparam logic [2:0] CSR_FIXED_POSITION  = 3'd6;
   localparam logic [2:0] CSR_FIXED_INTERVAL  = 3'd7;

   localparam int          SCALE          = 1000;
   localparam logic [9:0]  POSITION_BIAS  = 10'd256;
   localparam logic [9:0]  FIXED_POS_RST  = 10'd256;
   // ceil(2^40 / 1000); exact floor division for magnitudes up to 2^31
   localparam logic [30:0] RECIP_1000     = 31'd1099511628;
   localparam int          RECIP_SHIFT    = 40;

   typedef enum logic [3:0] {
      ST_STARTING = 4'b0001,
      ST_CLOSE    = 4'b0010,
      ST_FIXED    = 4'b0100,
      ST_MOD      = 4'b1000
   } mode_type;

   typedef struct packed {
      logic              control_mode;
      logic [9:0]        manual_position;
      logic signed [15:0] setpoint;
      logic [13:0]       gain_p;
      logic [13:0]       gain_i;
      logic [23:0]       int_limit;
      logic [9:0]        fixed_position;
      logic [30:0]       fixed_interval;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  req_status;
      logic [9:0]  valve_pos;
      logic [31:0] now_tick;
   } item_type;

   // after the multipliers
   typedef struct packed {
      item_type           item;
      logic signed [31:0] prod_i;
      logic signed [31:0] prod_p;
   } prod_type;

   // after the divide by 1000
   typedef struct packed {
      item_type           item;
      logic signed [21:0] q_i;
      logic signed [21:0] p_corr;
   } corr_type;

   // result before the final target scaling
   typedef struct packed {
      logic               target_sel;   // 1: target from target_sum
      logic signed [25:0] target_sum;
      logic [9:0]         target_lit;
      logic               accepted;
      logic [1:0]         status;
      logic               slow;
      logic               preload;
   } res_type;

   // signed divide by 1000, truncating toward zero
   function automatic logic signed [31:0] div1000(input logic signed [31:0] n);
      logic [31:0] mag;
      logic [62:0] prod;
      logic [22:0] qm;
      mag  = n[31] ? 32'(-n) : 32'(n);
      prod = 63'(mag) * 63'(RECIP_1000);
      qm   = prod[62:RECIP_SHIFT];
      return n[31] ? -signed'(32'(qm)) : signed'(32'(qm));
   endfunction

   // symmetric clamp of the integral to +-lim
   function automatic logic signed [24:0] clamp_int(input logic signed [25:0] v,
                                                   input logic [23:0] lim);
      logic signed [25:0] ls;
      logic signed [25:0] r;
      ls = signed'({2'b00, lim});
      r  = v;
      if (r < -ls) r = -ls;
      if (r > ls) r = ls;
      return 25'(r);
   endfunction

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         ST_STARTING: c = STATUS_STARTING;
         ST_CLOSE:    c = STATUS_CLOSE;
         ST_FIXED:    c = STATUS_FIXED;
         ST_MOD:      c = STATUS_MOD;
         default:     c = STATUS_STARTING;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/svpi_csr.sv -----
// Configuration register file, write only.
`timescale 1ns / 1ps
`default_nettype none

module svpi_csr
   import svpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CONTROL_MODE:    cfg_in.control_mode    = csr_wdata[0];
            CSR_MANUAL_POSITION: cfg_in.manual_position = csr_wdata[9:0];
            CSR_SETPOINT:        cfg_in.setpoint        = signed'(csr_wdata[15:0]);
            CSR_GAIN_P:          cfg_in.gain_p          = csr_wdata[13:0];
            CSR_GAIN_I:          cfg_in.gain_i          = csr_wdata[13:0];
            CSR_INT_LIMIT:       cfg_in.int_limit       = csr_wdata[23:0];
            CSR_FIXED_POSITION:  cfg_in.fixed_position  = csr_wdata[9:0];
            CSR_FIXED_INTERVAL:  cfg_in.fixed_interval  = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                 <= '0;
         cfg_ff.control_mode    <= 1'b1;
         cfg_ff.fixed_position  <= FIXED_POS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/svpi_front.sv -----
// Input register with the gain multipliers, then the divide-by-1000 stage.
`timescale 1ns / 1ps
`default_nettype none

module svpi_front
   import svpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  in_func,
   input  wire logic [79:0] in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output corr_type         out_item
);

   logic               s1_v_ff, s2_v_ff;
   prod_type           s1_ff, s1_in;
   corr_type           s2_ff, s2_in;
   logic               s1_ready, s2_ready;
   logic signed [17:0] diff;
   logic signed [14:0] gi_s, gp_s;

   assign s2_ready = !s2_v_ff || out_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   // diff = suction - evaporation - setpoint
   assign diff = 18'(signed'(in_data[17:2])) - 18'(signed'(in_data[33:18]))
               - 18'(cfg.setpoint);
   assign gi_s = signed'({1'b0, cfg.gain_i});
   assign gp_s = signed'({1'b0, cfg.gain_p});

   always_comb begin
      s1_in.item.func       = in_func;
      s1_in.item.req_status = in_data[1:0];
      s1_in.item.valve_pos  = in_data[43:34];
      s1_in.item.now_tick   = in_data[75:44];
      s1_in.prod_i          = 32'(diff) * 32'(gi_s);
      s1_in.prod_p          = 32'(diff) * 32'(gp_s);
   end

   always_comb begin
      s2_in.item   = s1_ff.item;
      s2_in.q_i    = 22'(div1000(s1_ff.prod_i));
      s2_in.p_corr = 22'(div1000(s1_ff.prod_p));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_v_ff <= in_valid;
         if (s2_ready) s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_v_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_v_ff;
   assign out_item  = s2_ff;

endmodule

`default_nettype wire

// ----- rtl/svpi_state.sv -----
// Mode machine, integral accumulator and hold timer; one item per cycle while the output side does not stall.
`timescale 1ns / 1ps
`default_nettype none

module svpi_state
   import svpi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire corr_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output res_type       out_res
);

   mode_type           mode_ff, mode_in;
   logic signed [24:0] integ_ff, integ_in;
   logic               sel_ff, sel_in;
   logic signed [25:0] sum_ff, sum_in;
   logic [9:0]         lit_ff, lit_in;
   logic [31:0]        hold_ff, hold_in;
   logic               slow_ff, slow_in;
   logic               v_ff;
   res_type            res_ff, res_in;
   logic               load;
   logic               acc;
   logic               pre;
   logic signed [24:0] integ_tick;
   logic signed [24:0] integ_preset;
   logic signed [10:0] fp_off;
   logic signed [21:0] preset_raw;
   logic [31:0]        elapsed;

   assign in_ready = !v_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign integ_tick = clamp_int(26'(integ_ff) + 26'(in_item.q_i), cfg.int_limit);
   assign fp_off       = signed'({1'b0, cfg.fixed_position}) - signed'({1'b0, POSITION_BIAS});
   assign preset_raw   = 22'(fp_off) * 22'(SCALE);
   assign integ_preset = clamp_int(26'(preset_raw), cfg.int_limit);
   assign elapsed      = in_item.item.now_tick - hold_ff;

   always_comb begin
      mode_in  = mode_ff;
      integ_in = integ_ff;
      sel_in   = sel_ff;
      sum_in   = sum_ff;
      lit_in   = lit_ff;
      hold_in  = hold_ff;
      slow_in  = slow_ff;
      acc      = 1'b0;
      pre      = 1'b0;
      if (in_item.item.func == FUNC_START) begin
         mode_in  = ST_STARTING;
         slow_in  = 1'b1;
         integ_in = '0;
         sel_in   = 1'b0;
         lit_in   = '0;
         pre      = 1'b1;
      end else begin
         // start-up done once the driver reports home
         if (mode_ff == ST_STARTING && in_item.item.valve_pos == '0) mode_in = ST_CLOSE;
         case (in_item.item.func)
            FUNC_TICK: begin
               if (!cfg.control_mode) begin
                  sel_in = 1'b0;
                  lit_in = cfg.manual_position;
               end else if (mode_in == ST_MOD) begin
                  integ_in = integ_tick;
                  sum_in   = 26'(in_item.p_corr) + 26'(integ_tick);
                  sel_in   = 1'b1;
               end else if (mode_in == ST_FIXED) begin
                  sel_in = 1'b0;
                  lit_in = cfg.fixed_position;
                  if (elapsed > {1'b0, cfg.fixed_interval}) begin
                     mode_in  = ST_MOD;
                     integ_in = integ_preset;
                     slow_in  = 1'b1;
                  end
               end
            end
            FUNC_REQ: begin
               if (mode_in == ST_CLOSE && in_item.item.req_status == STATUS_FIXED) begin
                  if (in_item.item.valve_pos == '0) begin
                     slow_in = 1'b0;
                     mode_in = ST_FIXED;
                     hold_in = in_item.item.now_tick;
                     acc     = 1'b1;
                  end
               end else if ((mode_in == ST_MOD || mode_in == ST_FIXED) &&
                            in_item.item.req_status == STATUS_CLOSE) begin
                  sel_in   = 1'b0;
                  lit_in   = '0;
                  integ_in = '0;
                  slow_in  = 1'b1;
                  mode_in  = ST_CLOSE;
                  acc      = 1'b1;
               end else if (mode_in == ST_FIXED &&
                            in_item.item.req_status == STATUS_FIXED) begin
                  hold_in = in_item.item.now_tick;
                  acc     = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      res_in.target_sel = sel_in;
      res_in.target_sum = sum_in;
      res_in.target_lit = lit_in;
      res_in.accepted   = acc;
      res_in.status     = mode_code(mode_in);
      res_in.slow       = slow_in;
      res_in.preload    = pre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ST_STARTING;
         integ_ff <= '0;
         sel_ff   <= 1'b0;
         sum_ff   <= '0;
         lit_ff   <= '0;
         hold_ff  <= '0;
         slow_ff  <= 1'b1;
         v_ff     <= 1'b0;
      end else begin
         if (in_ready) v_ff <= in_valid;
         if (load) begin
            mode_ff  <= mode_in;
            integ_ff <= integ_in;
            sel_ff   <= sel_in;
            sum_ff   <= sum_in;
            lit_ff   <= lit_in;
            hold_ff  <= hold_in;
            slow_ff  <= slow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res_in;
   end

   assign out_valid = v_ff;
   assign out_res   = res_ff;

   // a computed target exists only while modulating
   a_sel_mod: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> mode_ff == ST_MOD)
      else $error("computed target outside modulating mode");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.item.func == FUNC_START) |=> (mode_ff == ST_STARTING && slow_ff))
      else $error("start-up beat did not reset mode and speed");

   a_acc_req: assert property (@(posedge clock) disable iff (reset)
      (load && in_item.item.func != FUNC_REQ) |=> !res_ff.accepted)
      else $error("accept flag on a non-request beat");

endmodule

`default_nettype wire

// ----- rtl/svpi_out.sv -----
// Output stage: scales the PI sum to a step target (or passes the literal target) and packs the response beat.
`timescale 1ns / 1ps
`default_nettype none

module svpi_out
   import svpi_pkg::*;
#(
   parameter int MAX_STEP = 512
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire res_type in_res,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [31:0]  rsp_tdata
);

   localparam logic signed [31:0] MAX_S  = 32'(MAX_STEP);
   localparam logic signed [31:0] HALF_S = 32'(MAX_STEP / 2);

   logic               v_ff;
   logic [31:0]        data_ff, data_in;
   logic signed [31:0] t_raw;
   logic [9:0]         target;

   assign in_ready = !v_ff || rsp_tready;
   assign t_raw    = HALF_S + div1000(32'(in_res.target_sum));

   always_comb begin
      if (!in_res.target_sel) target = in_res.target_lit;
      else if (t_raw < 0) target = '0;
      else if (t_raw > MAX_S) target = 10'(MAX_STEP);
      else target = t_raw[9:0];
   end

   always_comb begin
      data_in        = '0;
      data_in[9:0]   = target;
      data_in[10]    = in_res.accepted;
      data_in[12:11] = in_res.status;
      data_in[13]    = in_res.slow;
      data_in[14]    = in_res.preload;
      data_in[24:15] = in_res.preload ? 10'(MAX_STEP) : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign rsp_tvalid = v_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/superheat_valve_pi_controller_core.sv -----
// Top level of the superheat expansion valve PI controller.
//
// Usage:
//   req_* beats carry one item each: req_tuser is the item kind (tick,
//   status request, start-up), req_tdata the request and the samples.
//   rsp_* returns exactly one beat per request beat, in order.
//   csr_* writes the eight configuration registers, one per cycle, no wait;
//   write them only while no beat is in flight.
// Timing:
//   Four register stages: multipliers, divide by 1000, mode/integral state,
//   target scaling. One beat per cycle is sustained while rsp_tready is
//   high; the integral feedback closes inside the state stage (one add and
//   clamp), so back-to-back ticks need no bubble.
// Reset:
//   synchronous; empties the pipe, mode starting, slow speed, integral and
//   target zero, registers to their defaults.
// Stall:
//   while rsp_tready is low each stage still fills its empty slot;
//   req_tready drops only once all four stages hold a beat.
`timescale 1ns / 1ps
`default_nettype none

module superheat_valve_pi_controller_core
   import svpi_pkg::*;
#(
   parameter int MAX_STEP = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] requested_status, [17:2] extra_temperature,
   // [33:18] evap_temp, [43:34] valve_position,
   // [75:44] now_tick, [79:76] zero
   input  wire logic [79:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [9:0] step_target, [10] request_accepted, [12:11] current_status,
   // [13] slow_step, [14] preload_valid, [24:15] preload_position,
   // [31:25] zero
   output logic [31:0]      rsp_tdata,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   cfg_type  cfg;
   logic     fr_valid, fr_ready;
   corr_type fr_item;
   logic     st_valid, st_ready;
   res_type  st_res;

   svpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stages 1 and 2: products, then scaled corrections
   svpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_data   (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   // stage 3: the only stage with feedback
   svpi_state u_state (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_res   (st_res)
   );

   // stage 4: target scaling and response register
   svpi_out #(
      .MAX_STEP (MAX_STEP)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (st_valid),
      .in_ready   (st_ready),
      .in_res     (st_res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
